### hw/rtl/prnf_pkg.sv
// Package for the padded radix number formatter.
// Shared constants, controller command and status structs. No dependencies.
`default_nettype none
package prnf_pkg;
    localparam int VALUE_BITS_DEF      = 32;
    localparam int MAX_FIELD_WIDTH_DEF = 62;
    localparam int MAX_CHARS           = 64;
    localparam int MAX_PREC            = 32;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736353433323130;
    localparam logic [63:0] DIGITS_HIGH_RST = 64'h6665646362613938;
    localparam logic CFG_DIGITS_LOW  = 1'b0;
    localparam logic CFG_DIGITS_HIGH = 1'b1;

    // char source selects
    localparam logic [2:0] SRC_SPACE  = 3'd0;
    localparam logic [2:0] SRC_PREFIX = 3'd1;
    localparam logic [2:0] SRC_ZERO   = 3'd2;
    localparam logic [2:0] SRC_DIGIT  = 3'd3;

    typedef struct packed {
        logic load;      // capture request, start conversion
        logic div_step;  // one division step
        logic emit;      // put a char in the output register
        logic [2:0] src;
        logic last;
    } prnf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic [6:0] lead_sp;   // leading space count
        logic [1:0] pre_n;     // prefix count
        logic [6:0] zero_n;    // zero pad count
        logic [6:0] dig_n;     // digit count
        logic ljust;
        logic [6:0] fw;
        logic out_busy;
    } prnf_stat_t;
endpackage
`default_nettype wire

### hw/rtl/prnf_datapath.sv
// Datapath: request capture, serial radix divider, digit store,
// character selection and output register. Uses prnf_pkg.
`default_nettype none
module prnf_datapath
    import prnf_pkg::*;
#(
    parameter int VALUE_BITS      = VALUE_BITS_DEF,
    parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic [4:0]            radix,
    input  wire logic [5:0]            min_width,
    input  wire logic signed [6:0]     precision,
    input  wire logic                  left_justify,
    input  wire logic                  zero_pad,
    input  wire logic                  use_prefix,
    input  wire logic [15:0]           prefix_chars,
    input  wire logic [1:0]            prefix_len,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_sel,
    input  wire logic [63:0]           cfg_data,
    input  wire prnf_cmd_t             cmd,
    input  wire logic                  idx,
    output prnf_stat_t                 stat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_char,
    output logic                       last_char
);
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [63:0] dlow_reg, dhigh_reg;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [3:0] rem_reg;
    logic [CW-1:0] bit_reg;
    logic [4:0] rad_reg;
    logic [6:0] len_reg;
    logic zero_val_reg, div_done_reg, ljust_reg, zpad_reg, usep_reg, nop_reg;
    logic [5:0] fw_reg;
    logic [5:0] prec_reg;
    logic [15:0] pch_reg;
    logic [1:0] plen_reg;
    // digit stack: newest (most significant) digit in the low nibble
    logic [4*VALUE_BITS-1:0] dstk_reg;
    logic [7:0] char_reg;
    logic last_reg, ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlow_reg  <= DIGITS_LOW_RST;
            dhigh_reg <= DIGITS_HIGH_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_sel == CFG_DIGITS_LOW)
                dlow_reg <= cfg_data;
            else
                dhigh_reg <= cfg_data;
        end
    end

    // restoring division: one value bit per cycle; a digit per full pass
    logic [4:0] rem_sh;
    logic ge;
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[VALUE_BITS-1]};
        ge = (rem_sh >= rad_reg);
    end

    logic [VALUE_BITS-1:0] qacc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_done_reg <= 1'b1;
        else if (cmd.load)
            div_done_reg <= 1'b0;
        else if (cmd.div_step && !div_done_reg && bit_reg == CW'(VALUE_BITS - 1)
                 && {qacc_reg[VALUE_BITS-2:0], ge} == '0)
            div_done_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= in_value;
            qacc_reg <= '0;
            rem_reg  <= '0;
            bit_reg  <= '0;
            len_reg  <= '0;
            rad_reg  <= (radix < 5'd2) ? 5'd2 : ((radix > 5'd16) ? 5'd16 : radix);
            zero_val_reg <= (in_value == '0);
            fw_reg   <= (min_width > 6'(MAX_FIELD_WIDTH)) ? 6'(MAX_FIELD_WIDTH)
                                                          : min_width;
            nop_reg  <= precision[6];
            prec_reg <= precision[6] ? 6'd0
                      : ((precision > 7'sd32) ? 6'd32 : precision[5:0]);
            ljust_reg <= left_justify;
            zpad_reg <= zero_pad;
            usep_reg <= use_prefix;
            pch_reg  <= prefix_chars;
            plen_reg <= (prefix_len == 2'd3) ? 2'd2 : prefix_len;
        end
        else if (cmd.div_step && !div_done_reg)
        begin
            if (bit_reg == CW'(VALUE_BITS - 1))
            begin
                dstk_reg <= {dstk_reg[4*VALUE_BITS-5:0],
                             (ge ? 4'(rem_sh - rad_reg) : rem_sh[3:0])};
                len_reg  <= len_reg + 7'd1;
                quo_reg  <= {qacc_reg[VALUE_BITS-2:0], ge};
                qacc_reg <= '0;
                rem_reg  <= '0;
                bit_reg  <= '0;
            end
            else
            begin
                rem_reg  <= ge ? 4'(rem_sh - rad_reg) : rem_sh[3:0];
                quo_reg  <= {quo_reg[VALUE_BITS-2:0], 1'b0};
                qacc_reg <= {qacc_reg[VALUE_BITS-2:0], ge};
                bit_reg  <= bit_reg + CW'(1);
            end
        end
        else if (cmd.emit && cmd.src == SRC_DIGIT)
            dstk_reg <= {4'd0, dstk_reg[4*VALUE_BITS-1:4]};
    end

    // counts
    logic [6:0] dig_n, tot, mx, pl;
    always_comb
    begin
        if (zero_val_reg)
            dig_n = (!nop_reg && prec_reg == 6'd0) ? 7'd0 : 7'd1;
        else
            dig_n = len_reg;
        pl  = usep_reg ? {5'd0, plen_reg} : 7'd0;
        tot = dig_n + pl;
        mx  = (!nop_reg && {1'b0, prec_reg} > tot) ? {1'b0, prec_reg} : tot;
        stat.lead_sp = (!ljust_reg && !zpad_reg && {1'b0, fw_reg} > mx)
                       ? 7'({1'b0, fw_reg} - mx) : 7'd0;
        stat.pre_n = usep_reg ? plen_reg : 2'd0;
        if (!ljust_reg && zpad_reg && nop_reg)
            stat.zero_n = ({1'b0, fw_reg} > dig_n) ? 7'({1'b0, fw_reg} - dig_n) : 7'd0;
        else
            stat.zero_n = (!nop_reg && {1'b0, prec_reg} > dig_n)
                          ? 7'({1'b0, prec_reg} - dig_n) : 7'd0;
        stat.dig_n = dig_n;
        stat.ljust = ljust_reg;
        stat.fw = {1'b0, fw_reg};
        stat.div_done = div_done_reg;
        stat.out_busy = ov_reg && !out_ready;
    end

    logic [3:0] dsel;
    logic [7:0] ch;
    always_comb
    begin
        dsel = zero_val_reg ? 4'd0 : dstk_reg[3:0];
        case (cmd.src)
            SRC_SPACE:  ch = SPACE_CHAR;
            SRC_PREFIX: ch = idx ? pch_reg[15:8] : pch_reg[7:0];
            SRC_ZERO:   ch = dlow_reg[7:0];
            SRC_DIGIT:  ch = dsel[3] ? dhigh_reg[8*dsel[2:0] +: 8]
                                     : dlow_reg[8*dsel[2:0] +: 8];
            default:    ch = SPACE_CHAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= ch;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = ov_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;
endmodule
`default_nettype wire

### hw/rtl/prnf_ctrl.sv
// Controller: sequences division, then each output section.
// Uses prnf_pkg command/status structs.
`default_nettype none
module prnf_ctrl
    import prnf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  prnf_stat_t      stat,
    output prnf_cmd_t       cmd,
    output logic            idx
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    localparam logic [2:0] SEC_TRAIL = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] sec_reg, sec_next;     // SRC_* section or SEC_TRAIL
    logic [6:0] cnt_reg, cnt_next;     // chars left in section
    logic [6:0] n_reg, n_next;         // chars emitted so far

    // count for a section
    function automatic logic [6:0] sec_len(input logic [2:0] s, input prnf_stat_t st,
                                           input logic [6:0] n);
        case (s)
            SRC_SPACE:  sec_len = st.lead_sp;
            SRC_PREFIX: sec_len = {5'd0, st.pre_n};
            SRC_ZERO:   sec_len = st.zero_n;
            SRC_DIGIT:  sec_len = st.dig_n;
            SEC_TRAIL:  sec_len = (st.ljust && st.fw > n) ? 7'(st.fw - n) : 7'd0;
            default:    sec_len = 7'd0;
        endcase
    endfunction

    logic [2:0] nsec;
    logic found;
    logic [6:0] nlen;
    logic more;
    always_comb
    begin
        state_next = state_reg;
        sec_next = sec_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        cmd = '0;
        in_ready = (state_reg == ST_IDLE);
        cmd.src = (sec_reg == SEC_TRAIL) ? SRC_SPACE : sec_reg;
        idx = 1'b0;
        nsec = 3'd0;
        found = 1'b0;
        nlen = 7'd0;
        more = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_CALC;
                    sec_next = SRC_SPACE;
                    n_next = 7'd0;
                end
            end
            ST_CALC:
            begin
                // find next nonempty section from sec_reg
                for (int k = 0; k < 5; k++)
                begin
                    if (!found && 3'(k) >= sec_reg && sec_len(3'(k), stat, n_reg) != 7'd0)
                    begin
                        found = 1'b1;
                        nsec = 3'(k);
                        nlen = sec_len(3'(k), stat, n_reg);
                    end
                end
                if (found)
                begin
                    sec_next = nsec;
                    cnt_next = nlen;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sec_reg == SRC_PREFIX)
                    idx = 1'(stat.pre_n - 2'(cnt_reg));
                if (!stat.out_busy)
                begin
                    // is this the final char
                    for (int k = 0; k < 5; k++)
                    begin
                        if (3'(k) > sec_reg && sec_len(3'(k), stat, n_reg + cnt_reg) != 7'd0)
                            more = 1'b1;
                    end
                    cmd.emit = 1'b1;
                    cmd.last = (cnt_reg == 7'd1 && !more) || (n_reg == 7'(MAX_CHARS - 1));
                    n_next = n_reg + 7'd1;
                    cnt_next = cnt_reg - 7'd1;
                    if (cmd.last)
                        state_next = ST_IDLE;
                    else if (cnt_reg == 7'd1)
                    begin
                        sec_next = sec_reg + 3'd1;
                        state_next = ST_CALC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sec_reg <= SRC_SPACE;
            cnt_reg <= 7'd0;
            n_reg <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg <= sec_next;
            cnt_reg <= cnt_next;
            n_reg <= n_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/padded_radix_number_formatter_top.sv
// Top level of the padded radix number formatter.
// Instantiates prnf_ctrl and prnf_datapath; uses prnf_pkg.
`default_nettype none
// Formats one unsigned value per request into printf-style characters, one
// output request per character, last_char on the final one. A request first
// runs the serial restoring divider, one digit per full pass over the value
// bits, then emits its characters section by section, stalling while the
// output is not taken. One request at a time.
module padded_radix_number_formatter_top
    import prnf_pkg::*;
#(
    parameter int VALUE_BITS      = VALUE_BITS_DEF,
    parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           value,
    input  wire logic [4:0]            radix,
    input  wire logic [5:0]            min_width,
    input  wire logic signed [6:0]     precision,
    input  wire logic                  left_justify,
    input  wire logic                  zero_pad,
    input  wire logic                  use_prefix,
    input  wire logic [15:0]           prefix_chars,
    input  wire logic [1:0]            prefix_len,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_char,
    output logic                       last_char,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [63:0]           cfg_data
);
    prnf_cmd_t cmd;
    prnf_stat_t stat;
    logic idx;
    logic [VALUE_BITS-1:0] val_m;

    assign val_m = VALUE_BITS'({32'd0, value});

    prnf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .cmd(cmd), .idx(idx)
    );

    prnf_datapath #(.VALUE_BITS(VALUE_BITS), .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_value(val_m), .radix(radix),
        .min_width(min_width), .precision(precision),
        .left_justify(left_justify), .zero_pad(zero_pad), .use_prefix(use_prefix),
        .prefix_chars(prefix_chars), .prefix_len(prefix_len),
        .cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .idx(idx), .stat(stat),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_char(out_char), .last_char(last_char)
    );

`ifndef SYNTHESIS
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && !out_ready)) else $error("char overwritten");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_ready |-> !cmd.load) else $error("load while busy");
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> in_ready) else $error("not idle after last");
`endif
endmodule
`default_nettype wire

### tb/sv/padded_radix_number_formatter_checker.sv
// Checker for the padded radix number formatter: watches the request and
// character channels, predicts the formatted characters and compares them.
// Depends on prnf_pkg for shared constants.
`timescale 1ns / 100ps
module padded_radix_number_formatter_checker
    import prnf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [31:0]        value,
    input  wire logic [4:0]         radix,
    input  wire logic [5:0]         min_width,
    input  wire logic signed [6:0]  precision,
    input  wire logic               left_justify,
    input  wire logic               zero_pad,
    input  wire logic               use_prefix,
    input  wire logic [15:0]        prefix_chars,
    input  wire logic [1:0]         prefix_len,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [7:0]         out_char,
    input  wire logic               last_char,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_data,
    output int                      fail_count,
    output int                      pending_chars,
    output int                      chars_seen
);
    logic [63:0] glyphs_low;
    logic [63:0] glyphs_high;
    logic [8:0]  char_queue[$];

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [127:0] all;
        begin
            all = {glyphs_high, glyphs_low};
            return all[d*8 +: 8];
        end
    endfunction

    task automatic push_char(input logic [7:0] c, inout int n);
        begin
            if (n < MAX_CHARS)
            begin
                char_queue.push_back({1'b0, c});
                n++;
            end
        end
    endtask

    task automatic format_number(
        input logic [31:0] v_in, input logic [4:0] rdx_in, input logic [5:0] fw_in,
        input logic [6:0] prec_in, input logic lj, input logic zp, input logic up,
        input logic [15:0] pc, input logic [1:0] pl_in);
        int rdx, fw, prec, pl, len, total, pad, logical, n, i;
        logic [31:0] v;
        logic [3:0] digs[64];
        begin
            v = v_in;
            rdx = rdx_in;
            if (rdx < 2) rdx = 2;
            if (rdx > 16) rdx = 16;
            fw = fw_in;
            if (fw > MAX_FIELD_WIDTH_DEF) fw = MAX_FIELD_WIDTH_DEF;
            pl = (pl_in > 2) ? 2 : pl_in;
            if (prec_in[6]) prec = -1;
            else prec = (prec_in > 32) ? 32 : prec_in;
            len = 0;
            n = 0;
            logical = 0;
            if (v == 0)
            begin
                if (prec != 0)
                begin
                    digs[0] = 4'd0;
                    len = 1;
                end
            end
            else
            begin
                while (v != 0)
                begin
                    digs[len] = 4'(v % rdx);
                    len++;
                    v = v / rdx;
                end
            end
            total = len + (up ? pl : 0);
            if (!lj && !zp)
            begin
                pad = fw - ((total > prec) ? total : prec);
                for (; pad > 0; pad--, logical++) push_char(SPACE_CHAR, n);
            end
            if (up)
                for (i = 0; i < pl; i++, logical++) push_char(pc[i*8 +: 8], n);
            if (!lj && zp && prec == -1) pad = fw - len;
            else pad = prec - len;
            for (; pad > 0; pad--, logical++) push_char(glyph(4'd0), n);
            for (i = len - 1; i >= 0; i--, logical++) push_char(glyph(digs[i]), n);
            if (lj)
                for (; logical < fw; logical++) push_char(SPACE_CHAR, n);
            if (n > 0)
                char_queue[$][8] = 1'b1;
        end
    endtask

    assign pending_chars = char_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [8:0] exp_char;
        if (!rst_n)
        begin
            glyphs_low  <= DIGITS_LOW_RST;
            glyphs_high <= DIGITS_HIGH_RST;
            char_queue.delete();
            fail_count  <= 0;
            chars_seen  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DIGITS_LOW) glyphs_low <= cfg_data;
                else glyphs_high <= cfg_data;
            end
            if (out_valid && out_ready)
            begin
                chars_seen <= chars_seen + 1;
                if (char_queue.size() == 0)
                begin
                    $error("unexpected character %h", out_char);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_char = char_queue.pop_front();
                    if (out_char !== exp_char[7:0])
                    begin
                        $error("out_char expected %h actual %h", exp_char[7:0], out_char);
                        fail_count <= fail_count + 1;
                    end
                    else if (last_char !== exp_char[8])
                    begin
                        $error("last_char expected %b actual %b", exp_char[8], last_char);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                format_number(value, radix, min_width, precision, left_justify,
                              zero_pad, use_prefix, prefix_chars, prefix_len);
        end
    end
endmodule

### tb/sv/padded_radix_number_formatter_top_tb.sv
// Testbench top for the padded radix number formatter: clock, reset, request
// stimulus, receiver stalls and the verdict. Uses the checker module and prnf_pkg.
`timescale 1ns / 100ps
module padded_radix_number_formatter_top_tb;
    import prnf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [31:0] value = 0;
    logic [4:0] radix = 10;
    logic [5:0] min_width = 0;
    logic signed [6:0] precision = -1;
    logic left_justify = 0, zero_pad = 0, use_prefix = 0;
    logic [15:0] prefix_chars = 0;
    logic [1:0] prefix_len = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [7:0] out_char;
    logic last_char;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [63:0] cfg_data = 0;
    int fail_count, pending_chars, chars_seen;
    int idle_cycles = 0;
    int requests_sent = 0;
    int rx_stall = 0;
    bit hold_off = 0;
    bit rx_bursty = 1;

    always #5 clk = ~clk;

    padded_radix_number_formatter_top DUT (.*);
    padded_radix_number_formatter_checker u_checker (.*);

    task automatic send_request(
        input logic [31:0] v, input logic [4:0] r, input logic [5:0] fw,
        input logic [6:0] p, input logic lj, input logic zp, input logic up,
        input logic [15:0] pc, input logic [1:0] pl);
        int gap;
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if (rx_bursty == 0) gap = 0;
            if (gap != 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
            value <= v; radix <= r; min_width <= fw; precision <= p;
            left_justify <= lj; zero_pad <= zp; use_prefix <= up;
            prefix_chars <= pc; prefix_len <= pl;
            in_valid <= 1;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            requests_sent++;
        end
    endtask

    task automatic send_random;
        logic [6:0] p;
        logic [4:0] r;
        logic [31:0] v;
        begin
            case ($urandom_range(0, 3))
                0: p = 7'h7f;
                1: p = 7'($urandom_range(0, 40));
                2: p = 7'($urandom_range(0, 127));
                default: p = 7'($urandom_range(0, 8));
            endcase
            r = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(2, 16));
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom_range(0, 255);
                2: v = 0;
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            send_request(v, r, 6'($urandom_range(0, 63)), p, 1'($urandom), 1'($urandom),
                         1'($urandom), 16'($urandom), 2'($urandom));
        end
    endtask

    task automatic drain;
        begin
            in_valid <= 0;
            @(posedge clk);
            while (pending_chars != 0) @(posedge clk);
            repeat (300) @(posedge clk);
        end
    endtask

    task automatic write_digit_tables(input logic [63:0] lo, input logic [63:0] hi);
        begin
            cfg_we <= 1; cfg_index <= CFG_DIGITS_LOW; cfg_data <= lo;
            @(posedge clk);
            cfg_index <= CFG_DIGITS_HIGH; cfg_data <= hi;
            @(posedge clk);
            cfg_we <= 0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            out_ready <= 0;
        end
        else if (hold_off || (rx_bursty && $urandom_range(0, 3) == 0))
        begin
            out_ready <= 0;
            if (!hold_off && $urandom_range(0, 30) == 0)
                rx_stall <= $urandom_range(10, 60);
        end
        else
            out_ready <= 1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed
        send_request(0, 10, 0, -1, 0, 0, 0, 0, 0);
        send_request(0, 10, 5, 0, 0, 0, 0, 0, 0);
        send_request(0, 10, 0, 0, 0, 0, 0, 0, 0);
        send_request(32'hffffffff, 2, 63, -1, 0, 0, 1, 16'h7830, 2);
        send_request(32'hffffffff, 16, 20, 12, 0, 0, 1, 16'h5830, 2);
        send_request(32'hdeadbeef, 16, 20, -1, 0, 1, 1, 16'h7830, 2);
        send_request(12345, 8, 12, -1, 1, 1, 1, 16'h0030, 1);
        send_request(12345, 10, 62, 40, 1, 0, 0, 0, 0);
        send_request(255, 0, 10, 7'sd63, 0, 0, 0, 0, 0);
        send_request(255, 31, 10, -5, 0, 1, 1, 16'hffff, 3);
        send_request(7, 1, 6, 3, 0, 0, 1, 16'h2b2d, 3);
        send_request(999, 10, 3, 1, 0, 0, 0, 0, 0);
        send_request(35, 7, 9, -1, 0, 1, 0, 0, 0);
        send_request(1, 16, 1, 32, 1, 1, 1, 16'h8000, 2);
        drain();
        write_digit_tables(64'h0, 64'hffffffffffffffff);
        for (int i = 0; i < 40; i++) send_random();
        drain();
        write_digit_tables({$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < 150; i++) send_random();
        // long receiver hold-off while requests keep coming
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send_random();
        join
        drain();
        write_digit_tables(DIGITS_LOW_RST, DIGITS_HIGH_RST);
        rx_bursty = 0;
        for (int i = 0; i < 60; i++) send_random();
        rx_bursty = 1;
        for (int i = 0; i < 200; i++) send_random();
        drain();
        $display("Sent %0d requests, checked %0d characters over four digit tables.",
                 requests_sent, chars_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
